>>> rtl/core/plb_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// plb_pkg
// Shared types and constants for the positional list buffer: command and
// error codes, field widths, and the control and status bundles that join
// the controller and the datapath.
// ============================================================================
package plb_pkg;

    // Default configuration of the list storage.
    localparam int CAPACITY_DEF      = 64;
    localparam int ELEMENT_WIDTH_DEF = 16;

    // Fixed field widths of the stream payloads.
    localparam int CMD_W    = 2;
    localparam int POS_W    = 7;
    localparam int VALUE_W  = 16;
    localparam int ERR_W    = 2;
    localparam int COUNT_W  = 7;
    localparam int IN_W     = 32;
    localparam int OUT_W    = 32;

    // Request commands.
    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT  = 2'd0,
        CMD_DELETE  = 2'd1,
        CMD_CHANGE  = 2'd2,
        CMD_REVERSE = 2'd3
    } cmd_t;

    // Result codes.
    typedef enum logic [ERR_W-1:0] {
        ERR_OK        = 2'd0,
        ERR_OVERFLOW  = 2'd1,
        ERR_UNDERFLOW = 2'd2,
        ERR_ILLEGAL   = 2'd3
    } err_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_in;     // capture the accepted request
        logic latch_err;   // store the checked result code
        logic shift_init;  // set up pointers and count for a shift
        logic shift_run;   // move one element per cycle
        logic rd_pos;      // read the element at the request position
        logic cap_removed; // keep the element read by rd_pos
        logic wr_val;      // write the request value at the request position
        logic len_inc;
        logic len_dec;
        logic rv_init;     // set up the two ends of a reversal
        logic rv_rd_lo;
        logic rv_rd_hi;
        logic rv_wr_lo;
        logic rv_wr_hi;
        logic out_load;    // load the result register
    } plb_ctrl_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        cmd_t cmd;
        err_t err;
        logic shift_busy;
        logic rv_more;
        logic out_free;
    } plb_stat_t;

endpackage

>>> rtl/core/plb_ram.sv
`timescale 1ns / 1ps
// ============================================================================
// plb_ram
// Generic simple dual-port RAM: one write port and one read port with a
// registered read data output.
// ============================================================================
module plb_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port; the data holds until the next read.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/core/plb_ctrl.sv
`timescale 1ns / 1ps
// ============================================================================
// plb_ctrl
// Controller of the positional list buffer. Accepts one request at a time,
// checks it, sequences the element moves, and hands the result to the
// output register.
// ============================================================================
module plb_ctrl
    import plb_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      s_tvalid,
    output logic      s_tready,
    input  plb_stat_t stat,
    output plb_ctrl_t ctrl
);

    typedef enum logic [12:0] {
        ST_IDLE     = 13'b0000000000001,
        ST_CHECK    = 13'b0000000000010,
        ST_DEL_RD   = 13'b0000000000100,
        ST_DEL_CAP  = 13'b0000000001000,
        ST_SHIFT    = 13'b0000000010000,
        ST_INS_PUT  = 13'b0000000100000,
        ST_CHG_WR   = 13'b0000001000000,
        ST_RV_TEST  = 13'b0000010000000,
        ST_RV_RD_LO = 13'b0000100000000,
        ST_RV_RD_HI = 13'b0001000000000,
        ST_RV_WR_LO = 13'b0010000000000,
        ST_RV_WR_HI = 13'b0100000000000,
        ST_FINISH   = 13'b1000000000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign s_tready = (state_reg == ST_IDLE);

    // Next state and per-cycle datapath commands.
    always_comb
    begin
        state_next = state_reg;
        ctrl       = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    ctrl.load_in = 1'b1;
                    state_next   = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                ctrl.latch_err = 1'b1;
                if (stat.err != ERR_OK)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    unique case (stat.cmd)
                        CMD_INSERT:
                        begin
                            ctrl.shift_init = 1'b1;
                            state_next      = ST_SHIFT;
                        end
                        CMD_DELETE:
                        begin
                            state_next = ST_DEL_RD;
                        end
                        CMD_CHANGE:
                        begin
                            state_next = ST_CHG_WR;
                        end
                        default:
                        begin
                            ctrl.rv_init = 1'b1;
                            state_next   = ST_RV_TEST;
                        end
                    endcase
                end
            end
            ST_DEL_RD:
            begin
                ctrl.rd_pos = 1'b1;
                state_next  = ST_DEL_CAP;
            end
            ST_DEL_CAP:
            begin
                ctrl.cap_removed = 1'b1;
                ctrl.shift_init  = 1'b1;
                state_next       = ST_SHIFT;
            end
            ST_SHIFT:
            begin
                ctrl.shift_run = 1'b1;
                if (!stat.shift_busy)
                begin
                    if (stat.cmd == CMD_INSERT)
                    begin
                        state_next = ST_INS_PUT;
                    end
                    else
                    begin
                        ctrl.len_dec = 1'b1;
                        state_next   = ST_FINISH;
                    end
                end
            end
            ST_INS_PUT:
            begin
                ctrl.wr_val  = 1'b1;
                ctrl.len_inc = 1'b1;
                state_next   = ST_FINISH;
            end
            ST_CHG_WR:
            begin
                ctrl.wr_val = 1'b1;
                state_next  = ST_FINISH;
            end
            ST_RV_TEST:
            begin
                state_next = stat.rv_more ? ST_RV_RD_LO : ST_FINISH;
            end
            ST_RV_RD_LO:
            begin
                ctrl.rv_rd_lo = 1'b1;
                state_next    = ST_RV_RD_HI;
            end
            ST_RV_RD_HI:
            begin
                ctrl.rv_rd_hi = 1'b1;
                state_next    = ST_RV_WR_LO;
            end
            ST_RV_WR_LO:
            begin
                ctrl.rv_wr_lo = 1'b1;
                state_next    = ST_RV_WR_HI;
            end
            ST_RV_WR_HI:
            begin
                ctrl.rv_wr_hi = 1'b1;
                state_next    = ST_RV_TEST;
            end
            ST_FINISH:
            begin
                if (stat.out_free)
                begin
                    ctrl.out_load = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

>>> rtl/core/plb_dpath.sv
`timescale 1ns / 1ps
// ============================================================================
// plb_dpath
// Datapath of the positional list buffer: request registers, position
// checks, list length, element storage with its move pointers, and the
// result register on the output side.
// ============================================================================
module plb_dpath
    import plb_pkg::*;
#(
    parameter int CAPACITY      = CAPACITY_DEF,
    parameter int ELEMENT_WIDTH = ELEMENT_WIDTH_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic [IN_W-1:0]  in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [OUT_W-1:0] out_data,
    input  plb_ctrl_t        ctrl,
    output plb_stat_t        stat
);

    localparam int AW = $clog2(CAPACITY);
    localparam int LW = $clog2(CAPACITY + 1);
    localparam int CW = ((LW > POS_W) ? LW : POS_W) + 1;
    localparam int VW = (ELEMENT_WIDTH < VALUE_W) ? ELEMENT_WIDTH : VALUE_W;

    // Request registers.
    cmd_t                     cmd_reg;
    logic [POS_W-1:0]         pos_reg;
    logic [POS_W-1:0]         endp_reg;
    logic [ELEMENT_WIDTH-1:0] val_reg;

    // List state and result registers.
    logic [LW-1:0]            len_reg;
    logic [LW-1:0]            len_next;
    err_t                     err_reg;
    logic [ELEMENT_WIDTH-1:0] removed_reg;

    // Move engine registers.
    logic [AW-1:0]            rd_ptr_reg;
    logic [AW-1:0]            rd_ptr_next;
    logic [AW-1:0]            wr_ptr_reg;
    logic [AW-1:0]            wr_ptr_next;
    logic [LW-1:0]            rem_reg;
    logic [LW-1:0]            rem_next;
    logic                     pend_reg;
    logic                     pend_next;
    logic [AW-1:0]            lo_reg;
    logic [AW-1:0]            lo_next;
    logic [AW-1:0]            hi_reg;
    logic [AW-1:0]            hi_next;
    logic [ELEMENT_WIDTH-1:0] tmp_reg;

    // Output register.
    logic                     out_valid_reg;
    logic                     out_valid_next;
    logic [OUT_W-1:0]         out_data_reg;

    // Storage port signals.
    logic                     ram_we;
    logic [AW-1:0]            ram_waddr;
    logic [ELEMENT_WIDTH-1:0] ram_wdata;
    logic                     ram_re;
    logic [AW-1:0]            ram_raddr;
    logic [ELEMENT_WIDTH-1:0] ram_rdata;

    // Compare-width copies of positions and length.
    logic [CW-1:0] pos_c;
    logic [CW-1:0] endp_c;
    logic [CW-1:0] len_c;
    logic [AW-1:0] pos_idx;
    logic          pos_ok;
    logic          endp_ok;
    logic          shift_go;
    err_t          err_chk;

    assign pos_c   = CW'(pos_reg);
    assign endp_c  = CW'(endp_reg);
    assign len_c   = CW'(len_reg);
    assign pos_idx = AW'(pos_c - CW'(1));
    assign pos_ok  = (pos_c != '0) && (pos_c <= len_c);
    assign endp_ok = (endp_c != '0) && (endp_c <= len_c);

    // Request check; capacity and emptiness come before the position.
    always_comb
    begin
        err_chk = ERR_OK;
        unique case (cmd_reg)
            CMD_INSERT:
            begin
                if (len_c >= CW'(CAPACITY))
                begin
                    err_chk = ERR_OVERFLOW;
                end
                else if (!(pos_ok || (pos_c == len_c + CW'(1))))
                begin
                    err_chk = ERR_ILLEGAL;
                end
            end
            CMD_DELETE:
            begin
                if (len_reg == '0)
                begin
                    err_chk = ERR_UNDERFLOW;
                end
                else if (!pos_ok)
                begin
                    err_chk = ERR_ILLEGAL;
                end
            end
            CMD_CHANGE:
            begin
                if (!pos_ok)
                begin
                    err_chk = ERR_ILLEGAL;
                end
            end
            default:
            begin
                if (!endp_ok || !pos_ok)
                begin
                    err_chk = ERR_ILLEGAL;
                end
            end
        endcase
    end

    // Request, result and scratch registers.
    always_ff @(posedge clk)
    begin
        if (ctrl.load_in)
        begin
            cmd_reg  <= cmd_t'(in_data[CMD_W-1:0]);
            pos_reg  <= in_data[CMD_W +: POS_W];
            endp_reg <= in_data[CMD_W + POS_W +: POS_W];
            val_reg  <= ELEMENT_WIDTH'(in_data[CMD_W + 2*POS_W +: VW]);
        end
        if (ctrl.latch_err)
        begin
            err_reg <= err_chk;
        end
        if (ctrl.load_in)
        begin
            removed_reg <= '0;
        end
        else if (ctrl.cap_removed)
        begin
            removed_reg <= ram_rdata;
        end
        if (ctrl.rv_rd_hi)
        begin
            tmp_reg <= ram_rdata;
        end
    end

    // List length.
    always_comb
    begin
        len_next = len_reg;
        if (ctrl.len_inc)
        begin
            len_next = len_reg + LW'(1);
        end
        else if (ctrl.len_dec)
        begin
            len_next = len_reg - LW'(1);
        end
    end

    // Shift engine: one read and the write of the previous read per cycle.
    assign shift_go = ctrl.shift_run && (rem_reg != '0);

    always_comb
    begin
        rd_ptr_next = rd_ptr_reg;
        wr_ptr_next = wr_ptr_reg;
        rem_next    = rem_reg;
        pend_next   = pend_reg;
        if (ctrl.shift_init)
        begin
            pend_next = 1'b0;
            if (cmd_reg == CMD_INSERT)
            begin
                rem_next    = LW'(len_c - pos_c + CW'(1));
                rd_ptr_next = AW'(len_c - CW'(1));
                wr_ptr_next = AW'(len_c);
            end
            else
            begin
                rem_next    = LW'(len_c - pos_c);
                rd_ptr_next = AW'(pos_c);
                wr_ptr_next = pos_idx;
            end
        end
        else if (ctrl.shift_run)
        begin
            pend_next = shift_go;
            if (shift_go)
            begin
                rem_next    = rem_reg - LW'(1);
                rd_ptr_next = (cmd_reg == CMD_INSERT) ? rd_ptr_reg - AW'(1)
                                                      : rd_ptr_reg + AW'(1);
            end
            if (pend_reg)
            begin
                wr_ptr_next = (cmd_reg == CMD_INSERT) ? wr_ptr_reg - AW'(1)
                                                      : wr_ptr_reg + AW'(1);
            end
        end
    end

    // Reversal ends.
    always_comb
    begin
        lo_next = lo_reg;
        hi_next = hi_reg;
        if (ctrl.rv_init)
        begin
            lo_next = pos_idx;
            hi_next = AW'(endp_c - CW'(1));
        end
        else if (ctrl.rv_wr_hi)
        begin
            lo_next = lo_reg + AW'(1);
            hi_next = hi_reg - AW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        rd_ptr_reg <= rd_ptr_next;
        wr_ptr_reg <= wr_ptr_next;
        rem_reg    <= rem_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
    end

    // Storage read port select.
    always_comb
    begin
        ram_re    = 1'b0;
        ram_raddr = rd_ptr_reg;
        if (shift_go)
        begin
            ram_re    = 1'b1;
            ram_raddr = rd_ptr_reg;
        end
        else if (ctrl.rd_pos)
        begin
            ram_re    = 1'b1;
            ram_raddr = pos_idx;
        end
        else if (ctrl.rv_rd_lo)
        begin
            ram_re    = 1'b1;
            ram_raddr = lo_reg;
        end
        else if (ctrl.rv_rd_hi)
        begin
            ram_re    = 1'b1;
            ram_raddr = hi_reg;
        end
    end

    // Storage write port select.
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = wr_ptr_reg;
        ram_wdata = ram_rdata;
        if (ctrl.shift_run && pend_reg)
        begin
            ram_we    = 1'b1;
            ram_waddr = wr_ptr_reg;
            ram_wdata = ram_rdata;
        end
        else if (ctrl.wr_val)
        begin
            ram_we    = 1'b1;
            ram_waddr = pos_idx;
            ram_wdata = val_reg;
        end
        else if (ctrl.rv_wr_lo)
        begin
            ram_we    = 1'b1;
            ram_waddr = lo_reg;
            ram_wdata = ram_rdata;
        end
        else if (ctrl.rv_wr_hi)
        begin
            ram_we    = 1'b1;
            ram_waddr = hi_reg;
            ram_wdata = tmp_reg;
        end
    end

    plb_ram #(
        .WIDTH (ELEMENT_WIDTH),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Output register: loads a result and holds it until taken.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (ctrl.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.out_load)
        begin
            out_data_reg <= {(OUT_W - VALUE_W - ERR_W - COUNT_W)'(0),
                             COUNT_W'(len_reg),
                             err_reg,
                             VALUE_W'(removed_reg[VW-1:0])};
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg       <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            len_reg       <= len_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign out_data        = out_data_reg;
    assign stat.cmd        = cmd_reg;
    assign stat.err        = err_chk;
    assign stat.shift_busy = (rem_reg != '0) || pend_reg;
    assign stat.rv_more    = (lo_reg < hi_reg);
    assign stat.out_free   = !out_valid_reg || out_ready;

endmodule

>>> rtl/core/positional_list_buffer_top.sv
`timescale 1ns / 1ps
// ============================================================================
// positional_list_buffer_top
// Bounded list of elements addressed by 1-based position, with insert,
// delete, change and range-reverse requests and one result per request.
//
//   Channel   Direction  Payload (lowest bit first)
//   s_axis    in         command[1:0], position[8:2], end_position[15:9],
//                        value_in[31:16]
//   m_axis    out        value_out[15:0], error_code[17:16], count[24:18],
//                        zero pad[31:25]
//
// One request is in work at a time; the element storage has one read and one
// write port. Insert and delete move the elements behind the position one at
// a time, and a reversal swaps its pairs one at a time. Reset clears the
// length and the output register; element contents stay as they are. A
// stalled result is held in the output register while the next request is
// already accepted; that request then waits in its last step until the held
// result is taken.
// ============================================================================
module positional_list_buffer_top
    import plb_pkg::*;
#(
    parameter int CAPACITY      = CAPACITY_DEF,
    parameter int ELEMENT_WIDTH = ELEMENT_WIDTH_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    // command, position, end_position, value_in
    input  logic [IN_W-1:0]  s_axis_tdata,
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    // value_out, error_code, count, zero pad
    output logic [OUT_W-1:0] m_axis_tdata
);

    plb_ctrl_t ctrl;
    plb_stat_t stat;

    plb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_axis_tvalid),
        .s_tready (s_axis_tready),
        .stat     (stat),
        .ctrl     (ctrl)
    );

    plb_dpath #(
        .CAPACITY      (CAPACITY),
        .ELEMENT_WIDTH (ELEMENT_WIDTH)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (s_axis_tdata),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata),
        .ctrl      (ctrl),
        .stat      (stat)
    );

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ============================================================================
// testbench
// Self-checking bench for the positional list buffer. A short table of
// directed requests covers the empty list, boundary positions and the underflow
// and illegal error codes; random requests follow, biased toward growing and then shrinking
// the list so that it reaches both ends of its capacity many times. Each
// accepted request runs through a shadow list kept here, and every result is
// compared field by field with the oldest pending expectation.
// ============================================================================
module testbench;

    import plb_pkg::*;

    localparam int CAPACITY      = CAPACITY_DEF;
    localparam int RANDOM_ITEMS  = 1250;
    localparam int STEADY_FROM   = 600;
    localparam int STEADY_TO     = 800;
    localparam int PAUSE_AT      = 1000;
    localparam int HOLD_AT       = 300;
    localparam int HOLD_CYCLES   = 400;
    localparam int DRAIN_CYCLES  = 300;
    localparam int CYCLE_LIMIT   = 1000000;

    // Request payload, command in the lowest bits.
    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [POS_W-1:0]   end_pos;
        logic [POS_W-1:0]   pos;
        cmd_t               cmd;
    } list_req_t;

    // Result payload, removed value in the lowest bits.
    typedef struct packed {
        logic [6:0]         zero_pad;
        logic [COUNT_W-1:0] count;
        err_t               err;
        logic [VALUE_W-1:0] value;
    } list_result_t;

    // One line of the directed table; fixed marks a result typed in by hand.
    typedef struct packed {
        list_req_t    req;
        logic         fixed;
        list_result_t res;
    } stim_row_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             s_axis_tvalid = 1'b0;
    logic             s_axis_tready;
    // command, position, end_position, value_in
    logic [IN_W-1:0]  s_axis_tdata = '0;
    logic             m_axis_tvalid;
    logic             m_axis_tready = 1'b0;
    // value_out, error_code, count, zero pad
    logic [OUT_W-1:0] m_axis_tdata;

    // Shadow copy of the list contents and its length.
    logic [VALUE_W-1:0] list_copy [CAPACITY];
    int                 list_len = 0;

    list_result_t pending_results [$];
    int           fail_count = 0;
    int           accepted_items = 0;
    int           cycle_count = 0;
    bit           steady = 1'b0;
    int           hold_left = 0;
    bit           hold_done = 1'b0;

    positional_list_buffer_top i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #4 clk = ~clk;

    // Apply one request to the shadow list and return the result it causes.
    function automatic list_result_t apply_list_command(list_req_t r);
        list_result_t res;
        int           p;
        int           e;
        int           j;
        int           lo;
        int           hi;
        logic [VALUE_W-1:0] swap;
        res = '0;
        p   = r.pos;
        e   = r.end_pos;
        case (r.cmd)
            CMD_INSERT:
            begin
                if (list_len >= CAPACITY)
                begin
                    res.err = ERR_OVERFLOW;
                end
                else if (p < 1 || p > list_len + 1)
                begin
                    res.err = ERR_ILLEGAL;
                end
                else
                begin
                    for (j = list_len; j >= p; j--)
                        list_copy[j] = list_copy[j-1];
                    list_copy[p-1] = r.value;
                    list_len++;
                end
            end
            CMD_DELETE:
            begin
                if (list_len == 0)
                begin
                    res.err = ERR_UNDERFLOW;
                end
                else if (p < 1 || p > list_len)
                begin
                    res.err = ERR_ILLEGAL;
                end
                else
                begin
                    res.value = list_copy[p-1];
                    for (j = p; j < list_len; j++)
                        list_copy[j-1] = list_copy[j];
                    list_len--;
                end
            end
            CMD_CHANGE:
            begin
                if (p < 1 || p > list_len)
                    res.err = ERR_ILLEGAL;
                else
                    list_copy[p-1] = r.value;
            end
            default:
            begin
                if (e < 1 || e > list_len || p < 1 || p > list_len)
                begin
                    res.err = ERR_ILLEGAL;
                end
                else
                begin
                    // A start at or above the end leaves the list as it is.
                    lo = p - 1;
                    hi = e - 1;
                    while (lo < hi)
                    begin
                        swap          = list_copy[lo];
                        list_copy[lo] = list_copy[hi];
                        list_copy[hi] = swap;
                        lo++;
                        hi--;
                    end
                end
            end
        endcase
        res.count = COUNT_W'(list_len);
        return res;
    endfunction

    function automatic stim_row_t row(cmd_t c, int p, int e, logic [VALUE_W-1:0] v,
                                      bit fixed = 1'b0, logic [VALUE_W-1:0] vo = '0,
                                      err_t er = ERR_OK, int cnt = 0);
        stim_row_t r;
        r.req.cmd     = c;
        r.req.pos     = POS_W'(p);
        r.req.end_pos = POS_W'(e);
        r.req.value   = v;
        r.fixed       = fixed;
        r.res         = '0;
        r.res.value   = vo;
        r.res.err     = er;
        r.res.count   = COUNT_W'(cnt);
        return r;
    endfunction

    // Offer one request, with random gaps ahead of it, and record its result.
    task automatic send_request(input list_req_t r, input bit fixed,
                                input list_result_t fixed_res);
        list_result_t predicted;
        while (!steady && $urandom_range(99) < 36)
        begin
            @(negedge clk);
            s_axis_tvalid <= 1'b0;
        end
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= r;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        predicted = apply_list_command(r);
        pending_results.push_back(fixed ? fixed_res : predicted);
        accepted_items++;
    endtask

    // Position draw for malformed requests: edges, just past the end, or any value.
    function automatic int edge_position();
        case ($urandom_range(4))
            0:       return 0;
            1:       return list_len;
            2:       return list_len + 1;
            3:       return list_len + 2;
            default: return $urandom_range(127);
        endcase
    endfunction

    // Receiver: random stalls, one long hold-off, none during the steady stretch.
    always @(negedge clk)
    begin
        if (!hold_done && accepted_items >= HOLD_AT)
        begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= steady || ($urandom_range(99) >= 36);
        end
    end

    // Compare each delivered result with the oldest expectation.
    always @(posedge clk)
    begin : check_result
        list_result_t want;
        list_result_t got;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = m_axis_tdata;
            if (pending_results.size() == 0)
            begin
                $error("result %h arrived with no request pending", got);
                fail_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.value !== want.value)
                begin
                    $error("value_out: expected %0h, got %0h", want.value, got.value);
                    fail_count++;
                end
                if (got.err !== want.err)
                begin
                    $error("error_code: expected %0d, got %0d", want.err, got.err);
                    fail_count++;
                end
                if (got.count !== want.count)
                begin
                    $error("count: expected %0d, got %0d", want.count, got.count);
                    fail_count++;
                end
                if (got.zero_pad !== want.zero_pad)
                begin
                    $error("zero pad: expected %0h, got %0h", want.zero_pad, got.zero_pad);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin : stimulus
        stim_row_t directed [$];
        list_req_t req;
        int        n;
        int        roll;
        bit        growing;

        // Empty list: every command fails, underflow ahead of the position check.
        directed.push_back(row(CMD_DELETE,  1, 0, 16'h0000, 1, 0, ERR_UNDERFLOW, 0));
        directed.push_back(row(CMD_DELETE,  0, 0, 16'h0000, 1, 0, ERR_UNDERFLOW, 0));
        directed.push_back(row(CMD_CHANGE,  1, 0, 16'h1234, 1, 0, ERR_ILLEGAL, 0));
        directed.push_back(row(CMD_REVERSE, 1, 1, 16'h0000, 1, 0, ERR_ILLEGAL, 0));
        directed.push_back(row(CMD_INSERT,  0, 0, 16'h0000, 1, 0, ERR_ILLEGAL, 0));
        directed.push_back(row(CMD_INSERT,  2, 0, 16'h0000, 1, 0, ERR_ILLEGAL, 0));
        // Build a short list: first entry, append, insert at the front.
        directed.push_back(row(CMD_INSERT,  1, 0, 16'hFFFF, 1, 0, ERR_OK, 1));
        directed.push_back(row(CMD_INSERT,  2, 0, 16'h0000, 1, 0, ERR_OK, 2));
        directed.push_back(row(CMD_INSERT,  1, 0, 16'h8001, 1, 0, ERR_OK, 3));
        directed.push_back(row(CMD_INSERT, 127, 127, 16'hFFFF, 1, 0, ERR_ILLEGAL, 3));
        directed.push_back(row(CMD_INSERT,  4, 0, 16'h5555, 1, 0, ERR_OK, 4));
        // Change and reverse, in range and just outside it.
        directed.push_back(row(CMD_CHANGE,  3, 0, 16'hA5A5, 1, 0, ERR_OK, 4));
        directed.push_back(row(CMD_CHANGE,  5, 0, 16'h0000, 1, 0, ERR_ILLEGAL, 4));
        directed.push_back(row(CMD_CHANGE,  0, 0, 16'h0000, 1, 0, ERR_ILLEGAL, 4));
        directed.push_back(row(CMD_REVERSE, 1, 4, 16'h0000, 1, 0, ERR_OK, 4));
        directed.push_back(row(CMD_REVERSE, 3, 2, 16'h0000, 1, 0, ERR_OK, 4));
        directed.push_back(row(CMD_REVERSE, 2, 2, 16'h0000, 1, 0, ERR_OK, 4));
        directed.push_back(row(CMD_REVERSE, 1, 5, 16'h0000, 1, 0, ERR_ILLEGAL, 4));
        directed.push_back(row(CMD_REVERSE, 0, 3, 16'h0000, 1, 0, ERR_ILLEGAL, 4));
        directed.push_back(row(CMD_REVERSE, 2, 3, 16'h0000));
        // Deletes: out of range, then from the middle, the end and the front.
        directed.push_back(row(CMD_DELETE,  0, 0, 16'h0000, 1, 0, ERR_ILLEGAL, 4));
        directed.push_back(row(CMD_DELETE,  5, 0, 16'h0000, 1, 0, ERR_ILLEGAL, 4));
        directed.push_back(row(CMD_DELETE,  2, 0, 16'h0000));
        directed.push_back(row(CMD_DELETE,  3, 0, 16'h0000));
        directed.push_back(row(CMD_DELETE,  1, 0, 16'h0000));

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed[i])
            send_request(directed[i].req, directed[i].fixed, directed[i].res);

        // Random requests, alternating between growing and shrinking the list.
        growing = 1'b1;
        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n == STEADY_FROM)
                steady = 1'b1;
            if (n == STEADY_TO)
                steady = 1'b0;
            if (n == PAUSE_AT)
            begin
                @(negedge clk);
                s_axis_tvalid <= 1'b0;
                while (pending_results.size() != 0)
                    @(posedge clk);
            end

            if (list_len == CAPACITY)
                growing = 1'b0;
            else if (list_len == 0)
                growing = 1'b1;
            else if ($urandom_range(99) < 3)
                growing = !growing;

            req.value = VALUE_W'($urandom);
            roll      = $urandom_range(99);
            if (roll < 6)
            begin
                req.cmd     = cmd_t'($urandom_range(3));
                req.pos     = POS_W'($urandom_range(127));
                req.end_pos = POS_W'($urandom_range(127));
            end
            else if (roll < 12)
            begin
                req.cmd     = cmd_t'($urandom_range(3));
                req.pos     = POS_W'(edge_position());
                req.end_pos = POS_W'(edge_position());
            end
            else
            begin
                roll = $urandom_range(99);
                if (roll < 60)
                    req.cmd = growing ? CMD_INSERT : CMD_DELETE;
                else if (roll < 75)
                    req.cmd = growing ? CMD_DELETE : CMD_INSERT;
                else if (roll < 90)
                    req.cmd = CMD_CHANGE;
                else
                    req.cmd = CMD_REVERSE;
                if (req.cmd == CMD_INSERT)
                    req.pos = POS_W'($urandom_range(1, list_len + 1));
                else
                    req.pos = POS_W'($urandom_range(1, (list_len > 0) ? list_len : 1));
                req.end_pos = POS_W'($urandom_range(1, (list_len > 0) ? list_len : 1));
            end
            send_request(req, 1'b0, '0);
        end

        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

>>> files.f
rtl/core/plb_pkg.sv
rtl/core/plb_ram.sv
rtl/core/plb_ctrl.sv
rtl/core/plb_dpath.sv
rtl/core/positional_list_buffer_top.sv
tb/testbench.sv
